### hdl/drive_to_point_pid_top_defines.svh
// Assertion macros shared by the drive-to-point controller RTL.
`ifndef DRIVE_TO_POINT_PID_TOP_DEFINES_SVH
`define DRIVE_TO_POINT_PID_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define DTP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dtp assertion failed");

// Next-cycle implication, clocked on clock, off during reset.
`define DTP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dtp assertion failed");

`endif

### hdl/dtp_pkg.sv
// Package: types, constants and helpers for the drive-to-point controller.
package dtp_pkg;

   localparam int FINISH_TICKS = 30;
   localparam int SQRT_STEPS   = 33;
   localparam int DIV_STEPS    = 33;

   localparam logic [32:0] Q_NEAR = 33'd58982;
   localparam logic [32:0] Q_HALF = 33'd32768;
   localparam logic signed [24:0] DEG90 = 25'sd5898240;
   localparam logic [20:0] TURN_P = 21'd1114;
   localparam logic [20:0] TURN_I = 21'd131;

   // register indexes
   localparam logic [2:0] CSR_TARGET_X = 3'd0;
   localparam logic [2:0] CSR_TARGET_Y = 3'd1;
   localparam logic [2:0] CSR_BASE_SPD = 3'd2;
   localparam logic [2:0] CSR_DRIVE_P  = 3'd3;
   localparam logic [2:0] CSR_DRIVE_I  = 3'd4;
   localparam logic [2:0] CSR_DRIVE_D  = 3'd5;
   localparam logic [2:0] CSR_CPS      = 3'd6;

   // register reset values
   localparam logic [16:0] RST_BASE_SPD = 17'd32768;
   localparam logic [20:0] RST_DRIVE_P  = 21'd16056;
   localparam logic [20:0] RST_DRIVE_I  = 21'd131;
   localparam logic [20:0] RST_DRIVE_D  = 21'd131;
   localparam logic [9:0]  RST_CPS      = 10'd50;

   typedef enum logic [4:0] {
      S_IDLE, S_SQX, S_SQY, S_SQRT, S_BRANCH, S_ADIV_INIT, S_ADIV, S_ASUM,
      S_QLO, S_QHI, S_QACC, S_TCLAMP, S_DDIV_INIT, S_DDIV, S_DE, S_DCLAMP, S_FIN
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_SQX, OP_SQY, OP_SQRT_STEP, OP_ADIV_INIT, OP_DDIV_INIT,
      OP_DIV_STEP, OP_ASUM, OP_QLO, OP_QHI, OP_QACC, OP_TCLAMP, OP_DE, OP_DCLAMP,
      OP_FIN
   } op_type;

   // which gain/operand product is in flight
   typedef enum logic [2:0] {
      Q_TURN_P, Q_TURN_I, Q_DRV_P, Q_DRV_I, Q_DRV_D
   } qsel_type;

   typedef struct packed {
      op_type   op;
      qsel_type qsel;
   } cmd_type;

   typedef struct packed {
      logic stage;
      logic far;
   } status_type;

   // saturate a 49-bit signed sum to 48 bits
   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      logic signed [47:0] r;
      if (v[48] != v[47]) begin
         r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

### hdl/dtp_req_if.sv
// Input channel interface: one control tick per transfer.
interface dtp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [24:0] heading_error;
   logic               turn_done;

   modport source (output valid, pos_x, pos_y, heading_error, turn_done, input ready);
   modport sink   (input valid, pos_x, pos_y, heading_error, turn_done, output ready);
endinterface

### hdl/dtp_rsp_if.sv
// Result channel interface: one motor command per transfer.
interface dtp_rsp_if;
   logic               valid;
   logic               ready;
   logic               stage;
   logic               turn_request;
   logic               motor_update;
   logic signed [18:0] left_power;
   logic signed [18:0] right_power;
   logic               finished;

   modport source (output valid, stage, turn_request, motor_update, left_power,
                   right_power, finished, input ready);
   modport sink   (input valid, stage, turn_request, motor_update, left_power,
                   right_power, finished, output ready);
endinterface

### hdl/dtp_datapath.sv
// Datapath: registers, shared multiplier, sqrt and divider steps, loop state.
module dtp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dtp_pkg::cmd_type     cmd,
   output dtp_pkg::status_type  status,
   input  logic signed [31:0]   pos_x,
   input  logic signed [31:0]   pos_y,
   input  logic signed [24:0]   heading_error,
   input  logic                 turn_done,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 out_stage,
   output logic                 out_turn_request,
   output logic                 out_motor_update,
   output logic signed [18:0]   out_left_power,
   output logic signed [18:0]   out_right_power,
   output logic                 out_finished
);

   // config
   logic signed [31:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [16:0] bs_ff, bs_in;
   logic [20:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [9:0]  cps_ff, cps_in;
   // tick operands
   logic [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [24:0] h_ff, h_in;
   logic done_ff, done_in;
   // sqrt
   logic [65:0] sq_ff, sq_in;
   logic [32:0] root_ff, root_in;
   logic [34:0] rem_ff, rem_in;
   // divider
   logic [32:0] dnum_ff, dnum_in;
   logic [17:0] drem_ff, drem_in, dden_ff, dden_in;
   // products and loops
   logic signed [71:0] acc_ff, acc_in;
   logic signed [55:0] q_ff, q_in;
   logic signed [57:0] turn_ff, turn_in, drive_ff, drive_in;
   logic signed [31:0] de_ff, de_in, last_ff, last_in;
   logic signed [47:0] asum_ff, asum_in, dsum_ff, dsum_in;
   logic stage_ff, stage_in;
   logic [7:0] ncnt_ff, ncnt_in;
   // result
   logic o_stage_ff, o_stage_in, o_req_ff, o_req_in, o_upd_ff, o_upd_in;
   logic o_fin_ff, o_fin_in;
   logic signed [18:0] o_left_ff, o_left_in, o_right_ff, o_right_in;

   // ---- combinational helpers
   logic signed [32:0] dx, dy, ndx, ndy;
   logic [9:0]  cps_eff;
   logic signed [25:0] h_ext, h_neg;
   logic [24:0] h_abs;
   logic h_big;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic [20:0] gain;
   logic signed [47:0] xq, de_diff;
   logic signed [71:0] q_sum;
   logic [1:0]  pair;
   logic [36:0] rem2, trial;
   logic [18:0] drem2;
   logic signed [25:0] ae;
   logic [26:0] lim1000;
   logic signed [47:0] asum_sat, dsum_sat;
   logic signed [33:0] de_pos, de34;
   logic signed [57:0] tmax, dmax;
   logic signed [19:0] tn, tn_abs, dr;
   logic signed [20:0] dr_minus;
   logic near;
   logic [7:0] ncnt_next;

   localparam logic signed [33:0] DE_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] DE_MIN = -34'sh0_8000_0000;

   assign dx  = $signed({tx_ff[31], tx_ff}) - $signed({pos_x[31], pos_x});
   assign dy  = $signed({ty_ff[31], ty_ff}) - $signed({pos_y[31], pos_y});
   assign ndx = -dx;
   assign ndy = -dy;
   assign cps_eff = (cps_ff == 10'd0) ? 10'd1 : cps_ff;
   assign h_ext = {h_ff[24], h_ff};
   assign h_neg = -h_ext;
   assign h_abs = h_ff[24] ? h_neg[24:0] : h_ff[24:0];
   assign h_big = (h_ff > dtp_pkg::DEG90) || (h_ff < -dtp_pkg::DEG90);
   assign de_diff = $signed({{16{de_ff[31]}}, de_ff}) - $signed({{16{last_ff[31]}}, last_ff});
   assign near = root_ff < dtp_pkg::Q_NEAR;

   always_comb begin
      case (cmd.qsel)
         dtp_pkg::Q_TURN_P: begin gain = dtp_pkg::TURN_P; xq = {{23{h_ff[24]}}, h_ff}; end
         dtp_pkg::Q_TURN_I: begin gain = dtp_pkg::TURN_I; xq = asum_ff; end
         dtp_pkg::Q_DRV_P:  begin gain = kp_ff; xq = {{16{de_ff[31]}}, de_ff}; end
         dtp_pkg::Q_DRV_I:  begin gain = ki_ff; xq = dsum_ff; end
         dtp_pkg::Q_DRV_D:  begin gain = kd_ff; xq = de_diff; end
         default:           begin gain = 21'd0; xq = 48'sd0; end
      endcase
   end

   // one shared multiplier
   always_comb begin
      case (cmd.op)
         dtp_pkg::OP_SQX: begin mul_a = {1'b0, ax_ff}; mul_b = {1'b0, ax_ff}; end
         dtp_pkg::OP_SQY: begin mul_a = {1'b0, ay_ff}; mul_b = {1'b0, ay_ff}; end
         dtp_pkg::OP_QLO: begin mul_a = {12'd0, gain}; mul_b = {9'd0, xq[23:0]}; end
         dtp_pkg::OP_QHI: begin mul_a = {12'd0, gain}; mul_b = {{9{xq[47]}}, xq[47:24]}; end
         default:         begin mul_a = 33'sd0; mul_b = 33'sd0; end
      endcase
   end
   assign prod  = mul_a * mul_b;
   assign q_sum = acc_ff + $signed({prod[47:0], 24'd0});

   assign pair  = sq_ff[65:64];
   assign rem2  = {rem_ff, pair};
   assign trial = {2'b00, root_ff, 2'b01};
   assign drem2 = {drem_ff, dnum_ff[32]};

   assign ae = h_ff[24] ? -$signed({1'b0, dnum_ff[24:0]}) : $signed({1'b0, dnum_ff[24:0]});
   assign lim1000 = {bs_ff, 10'd0} - 27'({bs_ff, 4'd0}) - 27'({bs_ff, 3'd0});
   assign asum_sat = dtp_pkg::sat48($signed({asum_ff[47], asum_ff}) + 49'($signed(ae)));
   assign dsum_sat = dtp_pkg::sat48($signed({dsum_ff[47], dsum_ff}) + 49'($signed(de_ff)));
   assign de_pos = $signed({1'b0, dnum_ff});
   assign de34   = h_big ? -de_pos : de_pos;
   assign tmax = $signed({40'd0, bs_ff, 1'b0});
   assign dmax = $signed({41'd0, bs_ff});
   assign tn = turn_ff[19:0];
   assign tn_abs = tn[19] ? -tn : tn;
   assign dr = drive_ff[19:0];
   assign dr_minus = $signed({dr[19], dr}) - $signed({tn_abs[19], tn_abs});
   assign ncnt_next = !near ? 8'd0 : ((ncnt_ff == 8'hFF) ? ncnt_ff : ncnt_ff + 8'd1);

   always_comb begin
      tx_in = tx_ff; ty_in = ty_ff; bs_in = bs_ff; kp_in = kp_ff; ki_in = ki_ff;
      kd_in = kd_ff; cps_in = cps_ff;
      ax_in = ax_ff; ay_in = ay_ff; h_in = h_ff; done_in = done_ff;
      sq_in = sq_ff; root_in = root_ff; rem_in = rem_ff;
      dnum_in = dnum_ff; drem_in = drem_ff; dden_in = dden_ff;
      acc_in = acc_ff; q_in = q_ff; turn_in = turn_ff; drive_in = drive_ff;
      de_in = de_ff; last_in = last_ff; asum_in = asum_ff; dsum_in = dsum_ff;
      stage_in = stage_ff; ncnt_in = ncnt_ff;
      o_stage_in = o_stage_ff; o_req_in = o_req_ff; o_upd_in = o_upd_ff;
      o_fin_in = o_fin_ff; o_left_in = o_left_ff; o_right_in = o_right_ff;

      if (csr_wr_en) begin
         case (csr_index)
            dtp_pkg::CSR_TARGET_X: tx_in  = csr_wdata;
            dtp_pkg::CSR_TARGET_Y: ty_in  = csr_wdata;
            dtp_pkg::CSR_BASE_SPD: bs_in  = csr_wdata[16:0];
            dtp_pkg::CSR_DRIVE_P:  kp_in  = csr_wdata[20:0];
            dtp_pkg::CSR_DRIVE_I:  ki_in  = csr_wdata[20:0];
            dtp_pkg::CSR_DRIVE_D:  kd_in  = csr_wdata[20:0];
            dtp_pkg::CSR_CPS:      cps_in = csr_wdata[9:0];
            default: ;
         endcase
      end

      case (cmd.op)
         dtp_pkg::OP_LOAD: begin
            ax_in = dx[32] ? ndx[31:0] : dx[31:0];
            ay_in = dy[32] ? ndy[31:0] : dy[31:0];
            h_in = heading_error;
            done_in = turn_done;
            turn_in = 58'sd0;
         end
         dtp_pkg::OP_SQX: sq_in = {2'b00, prod[63:0]};
         dtp_pkg::OP_SQY: begin
            sq_in = sq_ff + {2'b00, prod[63:0]};
            root_in = 33'd0;
            rem_in = 35'd0;
         end
         dtp_pkg::OP_SQRT_STEP: begin
            sq_in = {sq_ff[63:0], 2'b00};
            if (rem2 >= trial) begin
               rem_in = 35'(rem2 - trial);
               root_in = {root_ff[31:0], 1'b1};
            end else begin
               rem_in = rem2[34:0];
               root_in = {root_ff[31:0], 1'b0};
            end
         end
         dtp_pkg::OP_ADIV_INIT: begin
            dnum_in = {8'd0, h_abs};
            drem_in = 18'd0;
            dden_in = 18'(cps_eff) * 18'd180;
         end
         dtp_pkg::OP_DDIV_INIT: begin
            dnum_in = root_ff;
            drem_in = 18'd0;
            dden_in = {8'd0, cps_eff};
         end
         dtp_pkg::OP_DIV_STEP: begin
            if (drem2 >= {1'b0, dden_ff}) begin
               drem_in = 18'(drem2 - {1'b0, dden_ff});
               dnum_in = {dnum_ff[31:0], 1'b1};
            end else begin
               drem_in = drem2[17:0];
               dnum_in = {dnum_ff[31:0], 1'b0};
            end
         end
         dtp_pkg::OP_ASUM: begin
            if (ae == 26'sd0 || asum_sat > $signed({21'd0, lim1000})) begin
               asum_in = 48'sd0;
            end else begin
               asum_in = asum_sat;
            end
         end
         dtp_pkg::OP_QLO: acc_in = 72'(prod);
         dtp_pkg::OP_QHI: q_in = q_sum[71:16];
         dtp_pkg::OP_QACC: begin
            case (cmd.qsel)
               dtp_pkg::Q_TURN_P, dtp_pkg::Q_TURN_I: turn_in = turn_ff + 58'(q_ff);
               dtp_pkg::Q_DRV_P: begin
                  drive_in = 58'(q_ff);
                  if (de_ff == 32'sd0 || q_ff > $signed({39'd0, bs_ff})) begin
                     dsum_in = 48'sd0;
                  end else begin
                     dsum_in = dsum_sat;
                  end
               end
               default: drive_in = drive_ff + 58'(q_ff);
            endcase
         end
         dtp_pkg::OP_TCLAMP: begin
            if (turn_ff > tmax) begin
               turn_in = tmax;
            end else if (turn_ff < -tmax) begin
               turn_in = -tmax;
            end
         end
         dtp_pkg::OP_DE: begin
            if (de34 > DE_MAX) begin
               de_in = DE_MAX[31:0];
            end else if (de34 < DE_MIN) begin
               de_in = DE_MIN[31:0];
            end else begin
               de_in = de34[31:0];
            end
         end
         dtp_pkg::OP_DCLAMP: begin
            last_in = de_ff;
            if (drive_ff > dmax) begin
               drive_in = dmax;
            end else if (drive_ff < -dmax) begin
               drive_in = -dmax;
            end
         end
         dtp_pkg::OP_FIN: begin
            o_stage_in = stage_ff;
            ncnt_in = ncnt_next;
            o_fin_in = ncnt_next > 8'(dtp_pkg::FINISH_TICKS);
            if (!stage_ff) begin
               asum_in = 48'sd0;
               dsum_in = 48'sd0;
               last_in = 32'sd0;
               stage_in = done_ff;
               o_req_in = !done_ff;
               o_upd_in = 1'b0;
               o_left_in = 19'sd0;
               o_right_in = 19'sd0;
            end else begin
               o_req_in = 1'b0;
               o_upd_in = 1'b1;
               o_left_in = tn[19] ? dr_minus[18:0] : dr[18:0];
               o_right_in = tn[19] ? dr[18:0] : dr_minus[18:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff <= 32'sd0; ty_ff <= 32'sd0;
         bs_ff <= dtp_pkg::RST_BASE_SPD;
         kp_ff <= dtp_pkg::RST_DRIVE_P;
         ki_ff <= dtp_pkg::RST_DRIVE_I;
         kd_ff <= dtp_pkg::RST_DRIVE_D;
         cps_ff <= dtp_pkg::RST_CPS;
         stage_ff <= 1'b0;
         asum_ff <= 48'sd0; dsum_ff <= 48'sd0; last_ff <= 32'sd0;
         ncnt_ff <= 8'd0;
      end else begin
         tx_ff <= tx_in; ty_ff <= ty_in; bs_ff <= bs_in;
         kp_ff <= kp_in; ki_ff <= ki_in; kd_ff <= kd_in; cps_ff <= cps_in;
         stage_ff <= stage_in;
         asum_ff <= asum_in; dsum_ff <= dsum_in; last_ff <= last_in;
         ncnt_ff <= ncnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in; ay_ff <= ay_in; h_ff <= h_in; done_ff <= done_in;
      sq_ff <= sq_in; root_ff <= root_in; rem_ff <= rem_in;
      dnum_ff <= dnum_in; drem_ff <= drem_in; dden_ff <= dden_in;
      acc_ff <= acc_in; q_ff <= q_in; turn_ff <= turn_in; drive_ff <= drive_in;
      de_ff <= de_in;
      o_stage_ff <= o_stage_in; o_req_ff <= o_req_in; o_upd_ff <= o_upd_in;
      o_fin_ff <= o_fin_in; o_left_ff <= o_left_in; o_right_ff <= o_right_in;
   end

   assign status.stage = stage_ff;
   assign status.far   = root_ff >= dtp_pkg::Q_HALF;

   assign out_stage        = o_stage_ff;
   assign out_turn_request = o_req_ff;
   assign out_motor_update = o_upd_ff;
   assign out_left_power   = o_left_ff;
   assign out_right_power  = o_right_ff;
   assign out_finished     = o_fin_ff;

endmodule

### hdl/dtp_ctrl.sv
// Controller: sequences one tick through the datapath and owns both handshakes.
`include "drive_to_point_pid_top_defines.svh"

module dtp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dtp_pkg::status_type status,
   output dtp_pkg::cmd_type    cmd
);

   dtp_pkg::state_type state_ff, state_in;
   dtp_pkg::qsel_type  qsel_ff, qsel_in;
   logic [5:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtp_pkg::S_IDLE;
         qsel_ff <= dtp_pkg::Q_TURN_P;
         cnt_ff <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         qsel_ff <= qsel_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      qsel_in = qsel_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      cmd.op = dtp_pkg::OP_NONE;
      cmd.qsel = qsel_ff;
      case (state_ff)
         dtp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = dtp_pkg::OP_LOAD;
               state_in = dtp_pkg::S_SQX;
            end
         end
         dtp_pkg::S_SQX: begin
            cmd.op = dtp_pkg::OP_SQX;
            state_in = dtp_pkg::S_SQY;
         end
         dtp_pkg::S_SQY: begin
            cmd.op = dtp_pkg::OP_SQY;
            cnt_in = 6'd0;
            state_in = dtp_pkg::S_SQRT;
         end
         dtp_pkg::S_SQRT: begin
            cmd.op = dtp_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(dtp_pkg::SQRT_STEPS - 1)) begin
               state_in = dtp_pkg::S_BRANCH;
            end
         end
         dtp_pkg::S_BRANCH: begin
            if (!status.stage) begin
               state_in = dtp_pkg::S_FIN;
            end else if (status.far) begin
               state_in = dtp_pkg::S_ADIV_INIT;
            end else begin
               state_in = dtp_pkg::S_DDIV_INIT;
            end
         end
         dtp_pkg::S_ADIV_INIT: begin
            cmd.op = dtp_pkg::OP_ADIV_INIT;
            cnt_in = 6'd0;
            state_in = dtp_pkg::S_ADIV;
         end
         dtp_pkg::S_ADIV: begin
            cmd.op = dtp_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(dtp_pkg::DIV_STEPS - 1)) begin
               state_in = dtp_pkg::S_ASUM;
            end
         end
         dtp_pkg::S_ASUM: begin
            cmd.op = dtp_pkg::OP_ASUM;
            qsel_in = dtp_pkg::Q_TURN_P;
            state_in = dtp_pkg::S_QLO;
         end
         dtp_pkg::S_QLO: begin
            cmd.op = dtp_pkg::OP_QLO;
            state_in = dtp_pkg::S_QHI;
         end
         dtp_pkg::S_QHI: begin
            cmd.op = dtp_pkg::OP_QHI;
            state_in = dtp_pkg::S_QACC;
         end
         dtp_pkg::S_QACC: begin
            cmd.op = dtp_pkg::OP_QACC;
            state_in = dtp_pkg::S_QLO;
            case (qsel_ff)
               dtp_pkg::Q_TURN_P: qsel_in = dtp_pkg::Q_TURN_I;
               dtp_pkg::Q_TURN_I: state_in = dtp_pkg::S_TCLAMP;
               dtp_pkg::Q_DRV_P:  qsel_in = dtp_pkg::Q_DRV_I;
               dtp_pkg::Q_DRV_I:  qsel_in = dtp_pkg::Q_DRV_D;
               default:           state_in = dtp_pkg::S_DCLAMP;
            endcase
         end
         dtp_pkg::S_TCLAMP: begin
            cmd.op = dtp_pkg::OP_TCLAMP;
            state_in = dtp_pkg::S_DDIV_INIT;
         end
         dtp_pkg::S_DDIV_INIT: begin
            cmd.op = dtp_pkg::OP_DDIV_INIT;
            cnt_in = 6'd0;
            state_in = dtp_pkg::S_DDIV;
         end
         dtp_pkg::S_DDIV: begin
            cmd.op = dtp_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(dtp_pkg::DIV_STEPS - 1)) begin
               state_in = dtp_pkg::S_DE;
            end
         end
         dtp_pkg::S_DE: begin
            cmd.op = dtp_pkg::OP_DE;
            qsel_in = dtp_pkg::Q_DRV_P;
            state_in = dtp_pkg::S_QLO;
         end
         dtp_pkg::S_DCLAMP: begin
            cmd.op = dtp_pkg::OP_DCLAMP;
            state_in = dtp_pkg::S_FIN;
         end
         dtp_pkg::S_FIN: begin
            // result slot free or emptying this edge
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = dtp_pkg::OP_FIN;
               rsp_valid_in = 1'b1;
               state_in = dtp_pkg::S_IDLE;
            end
         end
         default: state_in = dtp_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `DTP_ASSERT_NXT(a_load_starts_tick, req_valid && req_ready, state_ff == dtp_pkg::S_SQX)
   `DTP_ASSERT_IMP(a_sqrt_count, state_ff == dtp_pkg::S_SQRT, cnt_ff < 6'(dtp_pkg::SQRT_STEPS))
   `DTP_ASSERT_NXT(a_fin_sets_valid, cmd.op == dtp_pkg::OP_FIN, rsp_valid_ff)
   `DTP_ASSERT_IMP(a_no_overwrite, rsp_valid_ff && !rsp_ready, cmd.op != dtp_pkg::OP_FIN)

endmodule

### hdl/drive_to_point_pid_top.sv
// Top level of the drive-to-point controller: controller, datapath and channels.
//
// One input transfer is one control tick and yields exactly one result
// transfer. A tick in the initial turn stage takes only the square root of
// the distance; in the drive stage it also runs the distance error and its
// gains once the robot is within 0.5 of the target, and the angle error and
// turn gains before those farther out. A finished result waits for a free
// output register. The work is done by the one-bit-per-cycle square root
// of the distance (33 steps) and the shared one-bit-per-cycle divider (33
// steps for the angle error, 33 for the distance error), with each gain
// product taken as two 24-bit halves through a single shared multiplier.
// A new tick is taken while the previous result still waits on the result
// channel. Register writes are taken every cycle but are only meant while
// the block is idle; a write to an index beyond the register list is dropped.
module drive_to_point_pid_top (
   input  logic        clock,
   input  logic        reset,
   dtp_req_if.sink     req_chan,
   dtp_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   dtp_pkg::cmd_type    cmd;      // per-cycle datapath command
   dtp_pkg::status_type status;   // stage and distance branch flags

   dtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // inputs are captured on the accepting transfer; result regs feed the channel
   dtp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .pos_x            (req_chan.pos_x),
      .pos_y            (req_chan.pos_y),
      .heading_error    (req_chan.heading_error),
      .turn_done        (req_chan.turn_done),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .out_stage        (rsp_chan.stage),
      .out_turn_request (rsp_chan.turn_request),
      .out_motor_update (rsp_chan.motor_update),
      .out_left_power   (rsp_chan.left_power),
      .out_right_power  (rsp_chan.right_power),
      .out_finished     (rsp_chan.finished)
   );

endmodule
